// ----- hdl/sorted_priority_queue_macros.svh -----
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hdl/spq_pkg.sv -----
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic       CMD_ENQUEUE  = 1'b0;
   localparam logic       CMD_DEQUEUE  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [31:0] data;
      logic        [7:0]  prio;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      ins;
      logic      del;
      entry_type item;
   } cell_ctrl_type;

endpackage

// ----- hdl/spq_cell.sv -----
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          left_stays,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          stays
);

   entry_type entry_ff;
   entry_type entry_in;

   // this entry sorts ahead of (or ties with) the new one
   assign stays = occupied && (entry_ff.prio <= ctrl.item.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.ins) begin
         if (stays) begin
            entry_in = entry_ff;
         end else if (left_stays) begin
            entry_in = ctrl.item;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.del) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- hdl/sorted_priority_queue.sv -----
// Sorted priority queue built as a row of entry cells, head in cell 0.
// Request channel: req_command (0 enqueue, 1 dequeue), req_item_data and
// req_item_priority are taken at a rising edge with start high and busy low.
// busy never rises, so a request beat may be issued every cycle.
// Enqueue places the entry after all stored entries of lower or equal
// priority; dequeue returns the head. Every request beat gives one response
// beat, rsp_valid high for one cycle, on the cycle after acceptance.
// rsp_status: ok, empty (dequeue with no entries), full (enqueue rejected).
// rsp_removed_* carry the head on a good dequeue and zero otherwise;
// rsp_occupancy is the entry count after the request.
// Throughput is one request per cycle: every cell
// decides locally from one priority compare and its neighbors' entries,
// and the whole row shifts in the same clock.
// The receiver cannot stall; responses must be taken as they appear.
// Synchronous reset empties the queue and drops any pending response;
// stored entries keep stale contents that are never read.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic signed [31:0] req_item_data,
   input  logic        [7:0]  req_item_priority,
   output logic               rsp_valid,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_removed_data,
   output logic        [7:0]  rsp_removed_priority,
   output logic        [4:0]  rsp_occupancy
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               valid_ff;
   logic        [1:0]  status_ff, status_in;
   entry_type          removed_ff, removed_in;

   logic          accept, is_full, is_empty;
   cell_ctrl_type ctrl;
   entry_type     cell_entry [QUEUE_DEPTH];
   logic          cell_stays [QUEUE_DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   assign ctrl.ins       = accept && (req_command == CMD_ENQUEUE) && !is_full;
   assign ctrl.del       = accept && (req_command == CMD_DEQUEUE) && !is_empty;
   assign ctrl.item.data = req_item_data;
   assign ctrl.item.prio = req_item_priority;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (COUNT_W'(i) < count_ff),
         .left_stays  ((i == 0) ? 1'b1 : cell_stays[(i == 0) ? 0 : i - 1]),
         .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
         .right_entry (cell_entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
         .entry       (cell_entry[i]),
         .stays       (cell_stays[i])
      );
   end

   always_comb begin
      count_in   = count_ff;
      status_in  = STATUS_OK;
      removed_in = '0;
      unique case (req_command)
         CMD_ENQUEUE: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         CMD_DEQUEUE: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in   = count_ff - COUNT_W'(1);
               removed_in = cell_entry[0];
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_data     = removed_ff.data;
   assign rsp_removed_priority = removed_ff.prio;
   assign rsp_occupancy        = 5'(count_ff);

`include "sorted_priority_queue_macros.svh"

   `SPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid, "missing response beat")
   `SPQ_ASSERT_NEXT(a_deq_count, clock, reset, ctrl.del, count_ff == $past(count_ff) - COUNT_W'(1), "dequeue count wrong")
   `SPQ_ASSERT_NEXT(a_enq_count, clock, reset, ctrl.ins, count_ff == $past(count_ff) + COUNT_W'(1), "enqueue count wrong")
   `SPQ_ASSERT_NOW(a_full_occ, clock, reset, rsp_valid && rsp_status == STATUS_FULL, count_ff == COUNT_W'(QUEUE_DEPTH), "full status with room")
   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(QUEUE_DEPTH), "count over depth")

endmodule

// ----- test/sorted_priority_queue_tb.sv -----
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int RANDOM_BEATS = 2000;
   localparam int CYCLE_LIMIT  = 60000;
   localparam int DIRECTED_N   = 24;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic [7:0]         prio;
      logic [4:0]         occupancy;
   } queue_reply_type;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] data;
      logic [7:0]         prio;
      logic               typed;
      queue_reply_type    reply;
   } queue_beat_type;

   localparam queue_reply_type NO_REPLY = '0;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = CMD_ENQUEUE;
   logic signed [31:0] req_item_data = '0;
   logic        [7:0]  req_item_priority = '0;
   logic               rsp_valid;
   logic        [1:0]  rsp_status;
   logic signed [31:0] rsp_removed_data;
   logic        [7:0]  rsp_removed_priority;
   logic        [4:0]  rsp_occupancy;

   sorted_priority_queue uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_item_data       (req_item_data),
      .req_item_priority   (req_item_priority),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_removed_data    (rsp_removed_data),
      .rsp_removed_priority(rsp_removed_priority),
      .rsp_occupancy       (rsp_occupancy)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // directed beats; typed replies are exact, the rest go through the predictor
   queue_beat_type script [DIRECTED_N] = '{
      '{CMD_DEQUEUE, 32'sh7FFF_FFFF, 8'd255, 1'b1, '{STATUS_EMPTY, 32'sd0, 8'd0, 5'd0}},
      '{CMD_ENQUEUE, 32'sh8000_0000, 8'd255, 1'b1, '{STATUS_OK, 32'sd0, 8'd0, 5'd1}},
      '{CMD_ENQUEUE, 32'sh7FFF_FFFF, 8'd0,   1'b1, '{STATUS_OK, 32'sd0, 8'd0, 5'd2}},
      '{CMD_ENQUEUE, 32'sd5,         8'd0,   1'b1, '{STATUS_OK, 32'sd0, 8'd0, 5'd3}},
      '{CMD_DEQUEUE, 32'sd0,         8'd0,   1'b1,
        '{STATUS_OK, 32'sh7FFF_FFFF, 8'd0, 5'd2}},
      '{CMD_DEQUEUE, 32'shFFFF_FFFF, 8'd255, 1'b1, '{STATUS_OK, 32'sd5, 8'd0, 5'd1}},
      '{CMD_DEQUEUE, 32'sh5555_AAAA, 8'd170, 1'b1,
        '{STATUS_OK, 32'sh8000_0000, 8'd255, 5'd0}},
      '{CMD_ENQUEUE, 32'sh0000_0101, 8'd128, 1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_0102, 8'd7,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_0103, 8'd255, 1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_0104, 8'd7,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'shFFFF_0105, 8'd0,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_0106, 8'd200, 1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_0107, 8'd7,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_0108, 8'd1,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh7FFF_0109, 8'd128, 1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_010A, 8'd254, 1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh8000_010B, 8'd0,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_010C, 8'd64,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_010D, 8'd7,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_010E, 8'd3,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_010F, 8'd255, 1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_0110, 8'd9,   1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'shFFFF_FFFF, 8'd0,   1'b1, '{STATUS_FULL, 32'sd0, 8'd0, 5'd16}}
   };

   logic signed [31:0] held_data [QUEUE_DEPTH];
   logic        [7:0]  held_prio [QUEUE_DEPTH];
   int                 held_count = 0;

   queue_reply_type pending_replies [$];
   queue_beat_type  issued_beats [$];

   int failures = 0;
   int replies_checked = 0;
   int enqueued = 0;
   int dequeued = 0;
   int full_rejects = 0;
   int empty_rejects = 0;
   int peak_occupancy = 0;
   int cycle_count = 0;

   function automatic queue_reply_type apply_queue_op(input logic cmd,
                                                      input logic signed [31:0] data,
                                                      input logic [7:0] prio);
      queue_reply_type r;
      int pos;
      r = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (held_count >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
            full_rejects++;
         end else begin
            pos = 0;
            while (pos < held_count && held_prio[pos] <= prio)
               pos++;
            for (int i = held_count; i > pos; i--) begin
               held_data[i] = held_data[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_data[pos] = data;
            held_prio[pos] = prio;
            held_count++;
            r.status = STATUS_OK;
            enqueued++;
         end
      end else if (held_count == 0) begin
         r.status = STATUS_EMPTY;
         empty_rejects++;
      end else begin
         r.status = STATUS_OK;
         r.data   = held_data[0];
         r.prio   = held_prio[0];
         for (int i = 1; i < held_count; i++) begin
            held_data[i-1] = held_data[i];
            held_prio[i-1] = held_prio[i];
         end
         held_count--;
         dequeued++;
      end
      r.occupancy = 5'(held_count);
      if (held_count > peak_occupancy)
         peak_occupancy = held_count;
      return r;
   endfunction

   always @(posedge clock) begin
      queue_reply_type want;
      queue_beat_type  row;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_replies.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected response beat: status %0d data %0d prio %0d occ %0d",
                           rsp_status, rsp_removed_data, rsp_removed_priority,
                           rsp_occupancy);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_status !== want.status || rsp_removed_data !== want.data ||
                   rsp_removed_priority !== want.prio ||
                   rsp_occupancy !== want.occupancy) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch at response %0d: expected status %0d data %0d ",
                               "prio %0d occ %0d, got status %0d data %0d prio %0d occ %0d"},
                              replies_checked, want.status, want.data, want.prio,
                              want.occupancy, rsp_status, rsp_removed_data,
                              rsp_removed_priority, rsp_occupancy);
               end
               replies_checked++;
            end
         end
         if (start && !busy) begin
            row = (issued_beats.size() != 0) ? issued_beats.pop_front() : '0;
            want = apply_queue_op(req_command, req_item_data, req_item_priority);
            if (row.typed)
               want = row.reply;
            pending_replies.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, pending_replies.size());
         $display("** sorted_priority_queue: FAILED **");
         $finish;
      end
   end

   // idle gaps before ~16% of beats
   task automatic send_beat(input queue_beat_type row, input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 99) < 16) begin
         gap = $urandom_range(1, 3);
         start             <= 1'b0;
         req_command       <= 1'($urandom);
         req_item_data     <= $urandom;
         req_item_priority <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_command       <= row.cmd;
      req_item_data     <= row.data;
      req_item_priority <= row.prio;
      issued_beats.push_back(row);
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [7:0] pick_priority();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return 8'($urandom_range(0, 3));
      if (r == 4)
         return 8'd0;
      if (r == 5)
         return 8'd255;
      return 8'($urandom);
   endfunction

   initial begin
      queue_beat_type row;
      bit filling;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (script[i])
         send_beat(script[i], 1'b1);
      // queue is full here: start by draining
      filling = 1'b0;
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 48 == 47)
            filling = !filling;
         row = '0;
         if ($urandom_range(0, 99) < 10)
            row.cmd = 1'($urandom);
         else if ($urandom_range(0, 99) < 80)
            row.cmd = filling ? CMD_ENQUEUE : CMD_DEQUEUE;
         else
            row.cmd = filling ? CMD_DEQUEUE : CMD_ENQUEUE;
         case ($urandom_range(0, 15))
            0: row.data = 32'sh8000_0000;
            1: row.data = 32'sh7FFF_FFFF;
            default: row.data = $urandom;
         endcase
         row.prio = pick_priority();
         send_beat(row, !(i >= 800 && i < 1200));
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0 || issued_beats.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("checked %0d responses: %0d enqueued, %0d dequeued, %0d full, %0d empty",
               replies_checked, enqueued, dequeued, full_rejects, empty_rejects);
      $display("peak occupancy %0d of %0d, %0d failures", peak_occupancy, QUEUE_DEPTH,
               failures);
      if (failures == 0)
         $display("** sorted_priority_queue: PASSED **");
      else
         $display("** sorted_priority_queue: FAILED **");
      $finish;
   end

endmodule
